// ===== rtl/top_k_keyed_score_list_core_assert.svh =====
// ----------------------------------------------------------------------------
// Top-K keyed score list assertion macros
// Shared property forms for the score list checks.
// ----------------------------------------------------------------------------
`ifndef TOP_K_KEYED_SCORE_LIST_CORE_ASSERT_SVH
`define TOP_K_KEYED_SCORE_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define TKL_CHECK_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKL_CHECK_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tkl_pkg.sv =====
// ----------------------------------------------------------------------------
// Top-K keyed score list package
// Field widths, codes, cell control types and defaults.
// ----------------------------------------------------------------------------
package tkl_pkg;

    localparam int SCORE_W         = 32;
    localparam int IN_KEY_W        = 16;
    localparam int CAP_W           = 5;
    localparam int RANK_W          = 4;
    localparam int OUT_CNT_W       = 5;
    localparam int IN_TDATA_W      = 48;
    localparam int OUT_TDATA_W     = 32;
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int KEY_BITS_DEF    = 16;
    localparam int CAP_RESET       = 16;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REJ_OWN  = 2'd1,
        STAT_REJ_LOW  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_CMP
    } t_state;

    typedef struct packed {
        logic load_new;
        logic take_prev;
    } t_cell_ctl;

    typedef struct packed {
        logic ge;
        logic match;
    } t_cell_flg;

endpackage

// ===== rtl/tkl_cell.sv =====
// ----------------------------------------------------------------------------
// Top-K keyed score list cell
// One list slot: holds a key and score, compares against a submission and
// loads either the new entry or its upper neighbor's entry.
// ----------------------------------------------------------------------------
module tkl_cell #(
    parameter int KEY_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmp_en,
    input  logic                          i_valid,
    input  logic [KEY_W-1:0]              i_cmp_key,
    input  logic signed [tkl_pkg::SCORE_W-1:0] i_cmp_score,
    input  tkl_pkg::t_cell_ctl            i_ctl,
    input  logic [KEY_W-1:0]              i_new_key,
    input  logic signed [tkl_pkg::SCORE_W-1:0] i_new_score,
    input  logic [KEY_W-1:0]              i_prev_key,
    input  logic signed [tkl_pkg::SCORE_W-1:0] i_prev_score,
    output logic [KEY_W-1:0]              o_key,
    output logic signed [tkl_pkg::SCORE_W-1:0] o_score,
    output tkl_pkg::t_cell_flg            o_flg
);
    import tkl_pkg::*;

    logic [KEY_W-1:0]          r_key;
    logic signed [SCORE_W-1:0] r_score;
    t_cell_flg                 r_flg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flg <= '0;
        end else if (i_cmp_en) begin
            r_flg.ge    <= i_valid && (r_score >= i_cmp_score);
            r_flg.match <= i_valid && (r_key == i_cmp_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_key   <= i_new_key;
            r_score <= i_new_score;
        end else if (i_ctl.take_prev) begin
            r_key   <= i_prev_key;
            r_score <= i_prev_score;
        end
    end

    assign o_key   = r_key;
    assign o_score = r_score;
    assign o_flg   = r_flg;

endmodule

// ===== rtl/tkl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Top-K keyed score list controller
// Takes submissions and capacity writes, decides from the cell flags and
// drives the shift/load of every cell and the result beat.
// ----------------------------------------------------------------------------
module tkl_ctrl #(
    parameter int MAX_ENTRIES = tkl_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = tkl_pkg::KEY_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tkl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tkl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [tkl_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic [KEY_BITS-1:0]               i_keys [MAX_ENTRIES],
    input  logic [MAX_ENTRIES-1:0]            i_ge,
    input  logic [MAX_ENTRIES-1:0]            i_match,
    output logic                              o_cmp_en,
    output logic [MAX_ENTRIES-1:0]            o_valid,
    output logic [KEY_BITS-1:0]               o_cmp_key,
    output logic signed [tkl_pkg::SCORE_W-1:0] o_cmp_score,
    output logic [KEY_BITS-1:0]               o_new_key,
    output logic signed [tkl_pkg::SCORE_W-1:0] o_new_score,
    output tkl_pkg::t_cell_ctl                o_ctl [MAX_ENTRIES]
);
    import tkl_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CAP_RST = (CAP_RESET > MAX_ENTRIES) ? MAX_ENTRIES : CAP_RESET;

    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_cap;
    logic [KEY_BITS-1:0]       r_key;
    logic signed [SCORE_W-1:0] r_score;
    logic                      r_m_valid;
    logic [OUT_TDATA_W-1:0]    r_m_data;
    logic [OUT_TDATA_W-1:0]    n_m_data;
    logic [CNT_W-1:0]          n_count;

    logic                      go;
    logic [31:0]               in_key32;
    logic [31:0]               cfg_eff32;
    logic [CNT_W-1:0]          cfg_eff;

    logic                      rej1;
    logic                      rej2;
    logic                      dup;
    logic                      ev;
    logic                      ins;
    logic                      full;
    logic [CNT_W-1:0]          pos;
    logic [CNT_W-1:0]          cnt_m1;
    logic [IDX_W-1:0]          last_ix;
    logic [31:0]               evk32;
    logic [31:0]               rank32;
    logic [31:0]               cnt32;
    logic [MAX_ENTRIES-1:0]    prev_ge;
    logic [MAX_ENTRIES-1:0]    m_below;
    t_status                   status;

    // submission fields
    assign in_key32    = 32'(s_axis_tdata[IN_KEY_W-1:0]);
    assign o_cmp_key   = in_key32[KEY_BITS-1:0];
    assign o_cmp_score = s_axis_tdata[IN_KEY_W +: SCORE_W];
    assign o_new_key   = r_key;
    assign o_new_score = r_score;

    // effective capacity of a register write
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_eff32 = 32'd1;
        end else if (32'(i_cfg_wdata) > 32'(MAX_ENTRIES)) begin
            cfg_eff32 = 32'(MAX_ENTRIES);
        end else begin
            cfg_eff32 = 32'(i_cfg_wdata);
        end
        cfg_eff = cfg_eff32[CNT_W-1:0];
    end

    always_comb begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            o_valid[j] = CNT_W'(j) < r_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_CMP;
            end
            S_CMP: begin
                if (go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_axis_tready = 1'b0;
        go            = 1'b0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_CMP:  go = !r_m_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                go            = 1'b0;
            end
        endcase
        o_cmp_en = s_axis_tvalid && s_axis_tready;
    end

    // decision from the cell flags
    always_comb begin
        rej1 = |(i_match & i_ge);
        dup  = |(i_match & ~i_ge);
        pos  = '0;
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            pos = pos + CNT_W'(i_ge[j]);
        end
        full = (r_count == r_cap);
        rej2 = !rej1 && !dup && full && (pos == r_count);
        ev   = !rej1 && !dup && !rej2 && full;
        ins  = !rej1 && !rej2;

        if (ins) begin
            n_count = r_count + CNT_W'(1) - CNT_W'(dup) - CNT_W'(ev);
        end else begin
            n_count = r_count;
        end

        cnt_m1  = r_count - CNT_W'(1);
        last_ix = cnt_m1[IDX_W-1:0];
        evk32   = ev ? 32'(i_keys[last_ix]) : 32'd0;
        rank32  = ins ? 32'(pos) : 32'd0;
        cnt32   = 32'(n_count);

        if (rej1) begin
            status = STAT_REJ_OWN;
        end else if (rej2) begin
            status = STAT_REJ_LOW;
        end else begin
            status = STAT_INSERTED;
        end

        n_m_data = '0;
        n_m_data[1:0]   = status;
        n_m_data[5:2]   = rank32[RANK_W-1:0];
        n_m_data[6]     = dup;
        n_m_data[7]     = ev;
        n_m_data[23:8]  = evk32[IN_KEY_W-1:0];
        n_m_data[28:24] = cnt32[OUT_CNT_W-1:0];
    end

    // per-cell load/shift
    always_comb begin
        prev_ge[0] = 1'b1;
        for (int j = 1; j < MAX_ENTRIES; j++) begin
            prev_ge[j] = i_ge[j-1];
        end
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            m_below[j] = |(i_match >> j);
        end
        for (int j = 0; j < MAX_ENTRIES; j++) begin
            o_ctl[j].load_new  = go && ins && prev_ge[j] && !i_ge[j];
            o_ctl[j].take_prev = go && ins && !prev_ge[j] && (!dup || m_below[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cap     <= CNT_W'(CAP_RST);
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= cfg_eff;
                if (r_count > cfg_eff) r_count <= cfg_eff;
            end else if (go) begin
                r_count <= n_count;
            end
            if (go) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmp_en) begin
            r_key   <= o_cmp_key;
            r_score <= o_cmp_score;
        end
        if (go) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

// ===== rtl/top_k_keyed_score_list_core.sv =====
// ----------------------------------------------------------------------------
// Top-K keyed score list core
// Holds the best (key, score) entries in descending score order, one entry
// per key, in a row of cells. In the accept cycle a submission is compared
// against every cell at once; in S_CMP the controller decides and shifts
// the row by at most one place while the result beat is registered. S_CMP
// waits while a previous result beat is still held on the output, and no
// new submission is accepted until the last one has left S_CMP.
// No clearing pass is needed after reset. It is up to the user that capacity
// writes are taken only while no submission is in flight; the core does not enforce this.
// ----------------------------------------------------------------------------
module top_k_keyed_score_list_core #(
    parameter int MAX_ENTRIES = tkl_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = tkl_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // player_key[15:0], score[47:16]
    input  logic [tkl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], rank[5:2], removed_duplicate[6], evicted[7],
    // evicted_key[23:8], entry_count[28:24], zero[31:29]
    output logic [tkl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [tkl_pkg::CAP_W-1:0]       i_cfg_wdata
);
    import tkl_pkg::*;

    logic                      cmp_en;
    logic [MAX_ENTRIES-1:0]    valid_vec;
    logic [KEY_BITS-1:0]       cmp_key;
    logic signed [SCORE_W-1:0] cmp_score;
    logic [KEY_BITS-1:0]       new_key;
    logic signed [SCORE_W-1:0] new_score;
    t_cell_ctl                 ctl [MAX_ENTRIES];
    t_cell_flg                 flg [MAX_ENTRIES];
    logic [KEY_BITS-1:0]       keys [MAX_ENTRIES];
    logic signed [SCORE_W-1:0] scores [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]    ge_vec;
    logic [MAX_ENTRIES-1:0]    match_vec;

    tkl_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_keys        (keys),
        .i_ge          (ge_vec),
        .i_match       (match_vec),
        .o_cmp_en      (cmp_en),
        .o_valid       (valid_vec),
        .o_cmp_key     (cmp_key),
        .o_cmp_score   (cmp_score),
        .o_new_key     (new_key),
        .o_new_score   (new_score),
        .o_ctl         (ctl)
    );

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [KEY_BITS-1:0]       prev_key;
        logic signed [SCORE_W-1:0] prev_score;

        if (g == 0) begin : g_head
            assign prev_key   = new_key;
            assign prev_score = new_score;
        end else begin : g_body
            assign prev_key   = keys[g-1];
            assign prev_score = scores[g-1];
        end

        tkl_cell #(
            .KEY_W (KEY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmp_en     (cmp_en),
            .i_valid      (valid_vec[g]),
            .i_cmp_key    (cmp_key),
            .i_cmp_score  (cmp_score),
            .i_ctl        (ctl[g]),
            .i_new_key    (new_key),
            .i_new_score  (new_score),
            .i_prev_key   (prev_key),
            .i_prev_score (prev_score),
            .o_key        (keys[g]),
            .o_score      (scores[g]),
            .o_flg        (flg[g])
        );

        assign ge_vec[g]    = flg[g].ge;
        assign match_vec[g] = flg[g].match;
    end

`include "top_k_keyed_score_list_core_assert.svh"

    `TKL_CHECK_NOW(a_key_unique, 1'b1, $onehot0(match_vec), "key held in more than one cell")
    `TKL_CHECK_NOW(a_ge_prefix, 1'b1, ((ge_vec & (ge_vec + 1'b1)) == '0), "score order broken")
    `TKL_CHECK_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken")

endmodule

// ===== verif/top_k_keyed_score_list_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K keyed score list checker
// Watches the submission, result and capacity ports, keeps its own ranked
// list of (key, score) entries, and compares every result beat field by
// field with the oldest predicted outcome. Reports a failure count.
// ----------------------------------------------------------------------------
module top_k_keyed_score_list_core_checker #(
    parameter int DEPTH = tkl_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // player_key[15:0], score[47:16]
    input  logic [tkl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[1:0], rank[5:2], removed_duplicate[6], evicted[7],
    // evicted_key[23:8], entry_count[28:24], zero[31:29]
    input  logic [tkl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [tkl_pkg::CAP_W-1:0]       i_cfg_wdata,
    output int                              o_err_count,
    output int                              o_pending,
    output int                              o_results
);
    import tkl_pkg::*;

    typedef struct packed {
        logic [2:0]           pad;
        logic [OUT_CNT_W-1:0] count;
        logic [15:0]          ev_key;
        logic                 evicted;
        logic                 dup;
        logic [RANK_W-1:0]    rank;
        t_status              status;
    } t_outcome;

    logic [15:0]        held_keys [DEPTH];
    logic signed [31:0] held_scores [DEPTH];
    int                 held_n;
    logic [CAP_W-1:0]   cap_reg;
    t_outcome           outcome_q [$];
    t_outcome           want;
    t_outcome           got;
    t_outcome           pred;

    function automatic int usable_slots();
        if (cap_reg == 0) return 1;
        if (int'(cap_reg) > DEPTH) return DEPTH;
        return int'(cap_reg);
    endfunction

    function automatic void set_capacity(input logic [CAP_W-1:0] value);
        cap_reg = value;
        if (held_n > usable_slots()) held_n = usable_slots();
    endfunction

    function automatic t_outcome rank_submission(input logic [15:0] key,
                                                 input logic signed [31:0] sc);
        t_outcome r;
        int       lim;
        int       hit;
        int       pos;
        int       i;
        r = '0;
        r.status = STAT_INSERTED;
        lim = usable_slots();
        if (held_n > lim) held_n = lim;
        hit = held_n;
        for (i = 0; i < held_n; i++) begin
            if (hit == held_n && held_keys[i] == key) hit = i;
        end
        if (hit < held_n) begin
            if (sc <= held_scores[hit]) begin
                r.status = STAT_REJ_OWN;
                r.count = 5'(held_n);
                return r;
            end
            for (i = hit; i + 1 < held_n; i++) begin
                held_keys[i]   = held_keys[i + 1];
                held_scores[i] = held_scores[i + 1];
            end
            held_n--;
            r.dup = 1'b1;
        end
        if (held_n >= lim) begin
            if (held_n == 0 || sc <= held_scores[held_n - 1]) begin
                r.status = STAT_REJ_LOW;
                r.count = 5'(held_n);
                return r;
            end
            r.evicted = 1'b1;
            r.ev_key = held_keys[held_n - 1];
            held_n--;
        end
        pos = 0;
        while (pos < held_n && !(sc > held_scores[pos])) pos++;
        for (i = held_n; i > pos; i--) begin
            held_keys[i]   = held_keys[i - 1];
            held_scores[i] = held_scores[i - 1];
        end
        held_keys[pos]   = key;
        held_scores[pos] = sc;
        held_n++;
        r.rank = 4'(pos);
        r.count = 5'(held_n);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_n = 0;
            cap_reg = 5'(CAP_RESET);
            outcome_q.delete();
            o_err_count = 0;
            o_results = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_outcome'(m_axis_tdata);
                o_results++;
                if (outcome_q.size() == 0) begin
                    o_err_count++;
                    if (o_err_count <= 10)
                        $display("[%0t] result beat with none expected: %h", $time,
                                 m_axis_tdata);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.status !== want.status || got.rank !== want.rank ||
                        got.dup !== want.dup || got.evicted !== want.evicted ||
                        got.ev_key !== want.ev_key || got.count !== want.count ||
                        got.pad !== want.pad) begin
                        o_err_count++;
                        if (o_err_count <= 10) begin
                            $display({"[%0t] mismatch exp: status=%0d rank=%0d dup=%b",
                                      " ev=%b key=%h cnt=%0d pad=%0d"},
                                     $time, want.status, want.rank, want.dup,
                                     want.evicted, want.ev_key, want.count, want.pad);
                            $display({"[%0t]          got: status=%0d rank=%0d dup=%b",
                                      " ev=%b key=%h cnt=%0d pad=%0d"},
                                     $time, got.status, got.rank, got.dup,
                                     got.evicted, got.ev_key, got.count, got.pad);
                        end
                    end
                end
            end
            if (i_cfg_we) set_capacity(i_cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                pred = rank_submission(s_axis_tdata[15:0], s_axis_tdata[47:16]);
                outcome_q = {outcome_q, pred};
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ===== verif/top_k_keyed_score_list_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K keyed score list testbench
// Drives score submissions and capacity writes into the core: a directed
// pass over duplicates, ties, full lists, capacity cuts and saturation,
// then random phases with a small key pool under mixed sender idling and
// receiver stalls. The checker predicts and compares; this module reports.
// ----------------------------------------------------------------------------
module top_k_keyed_score_list_core_test;
    import tkl_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 150;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CAP_W-1:0]       i_cfg_wdata;

    int          chk_errors;
    int          chk_pending;
    int          chk_results;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          submitted = 0;
    int          cap_writes = 0;
    int          quiet_cycles = 0;
    logic [15:0] key_pool [POOL_SIZE];

    top_k_keyed_score_list_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    top_k_keyed_score_list_core_checker u_score_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_err_count   (chk_errors),
        .o_pending     (chk_pending),
        .o_results     (chk_results)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[top_k_keyed_score_list_core] ERROR");
            $finish;
        end
    end

    // call at a falling edge; returns at the falling edge after the beat
    task automatic submit(input logic [15:0] key, input logic [31:0] sc);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sc, key};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        submitted++;
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    task automatic submit_random();
        logic [15:0] key;
        logic [31:0] sc;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 85) key = key_pool[$urandom_range(POOL_SIZE - 1)];
        else key = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 60) begin
            sc = $urandom_range(400) - 200;
        end else if (pick < 85) begin
            sc = $urandom;
        end else begin
            case ($urandom_range(3))
                0: sc = 32'h7FFF_FFFF;
                1: sc = 32'h8000_0000;
                2: sc = 32'h0000_0000;
                default: sc = 32'hFFFF_FFFF;
            endcase
        end
        submit(key, sc);
    endtask

    initial begin
        int phase_caps [6] = '{16, 1, 7, 17, 0, 12};
        int gap_mix [4]    = '{0, 63, 0, 22};
        int stall_mix [4]  = '{0, 0, 63, 22};
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        submit(16'h0000, 32'h0000_0000);
        submit(16'h0000, 32'h0000_0000);
        submit(16'h0000, 32'hFFFF_FFFF);
        submit(16'hFFFF, 32'h7FFF_FFFF);
        submit(16'h0000, 32'd5);
        submit(16'h1234, 32'h8000_0000);
        submit(16'hABCD, 32'd5);
        write_capacity(5'd2);
        submit(16'h5555, 32'h8000_0000);
        submit(16'hAAAA, 32'd5);
        submit(16'hAAAA, 32'd6);
        submit(16'hFFFF, 32'h7FFF_FFFF);
        submit(16'hAAAA, 32'd7);
        write_capacity(5'd0);
        submit(16'h0001, 32'h7FFF_FFFF);
        submit(16'hFFFF, 32'h0000_0000);
        submit(16'h0002, 32'hFFFF_FFFF);
        write_capacity(5'd31);
        for (int i = 0; i < 8; i++)
            submit(16'h0003 << (2 * i), 32'(i * 1000) - 32'd3000);

        for (int ph = 0; ph < 6; ph++) begin
            write_capacity(5'(phase_caps[ph]));
            for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = 16'($urandom);
            gap_pct   = gap_mix[ph % 4];
            stall_pct = stall_mix[ph % 4];
            for (int n = 0; n < PHASE_ITEMS; n++) submit_random();
        end

        s_axis_tvalid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Covered %0d submissions, %0d result beats, %0d capacity writes,",
                 submitted, chk_results, cap_writes);
        $display("with ties, duplicate keys, evictions and idle/stall mixes.");
        if (chk_errors == 0 && chk_pending == 0)
            $display("[top_k_keyed_score_list_core] OK");
        else
            $display("[top_k_keyed_score_list_core] ERROR");
        $finish;
    end

endmodule
